### hdl/raycast_wall_column_texel_mapper_defines.svh
// assertion macros shared by the texel mapper modules
`ifndef RAYCAST_WALL_COLUMN_TEXEL_MAPPER_DEFINES_SVH
`define RAYCAST_WALL_COLUMN_TEXEL_MAPPER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RCM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("texel mapper check failed");

// next-cycle implication, checked out of reset
`define RCM_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("texel mapper check failed");

`endif

### hdl/rcm_pkg.sv
// types, codes and sizes shared by the texel mapper modules
package rcm_pkg;

    // bus widths
    localparam int S_TDATA_W = 176;
    localparam int M_TDATA_W = 112;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    // dividend magnitude bits, one divider step per bit
    localparam int DIV_STEPS = 33;

    // register indexes
    localparam logic [2:0] REG_CEILING_COLOR  = 3'd0;
    localparam logic [2:0] REG_FLOOR_COLOR    = 3'd1;
    localparam logic [2:0] REG_TEXTURE_WIDTH  = 3'd2;
    localparam logic [2:0] REG_TEXTURE_HEIGHT = 3'd3;
    localparam logic [2:0] REG_SCREEN_WIDTH   = 3'd4;
    localparam logic [2:0] REG_SCREEN_HEIGHT  = 3'd5;
    localparam logic [2:0] REG_FRAME_PITCH    = 3'd6;

    // row classes
    localparam logic [1:0] REGION_CEILING = 2'd0;
    localparam logic [1:0] REGION_WALL    = 2'd1;
    localparam logic [1:0] REGION_FLOOR   = 2'd2;

    // wall textures
    localparam logic [1:0] TEX_WEST  = 2'd0;
    localparam logic [1:0] TEX_EAST  = 2'd1;
    localparam logic [1:0] TEX_NORTH = 2'd2;
    localparam logic [1:0] TEX_SOUTH = 2'd3;

    // configuration seen by the datapath
    typedef struct packed {
        logic [31:0] ceiling_color;
        logic [31:0] floor_color;
        logic [12:0] texture_width;
        logic [12:0] texture_height;
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic [13:0] frame_pitch;
    } cfg_t;

    // one pixel as it moves down the pipeline
    typedef struct packed {
        logic        side;
        logic [20:0] dir_x;
        logic [20:0] dir_y;
        logic [23:0] eye_x;
        logic [23:0] eye_y;
        logic [23:0] wall_dist;
        logic [19:0] lh;
        logic [11:0] top;
        logic [11:0] row;
        logic [11:0] col;
        logic [1:0]  region;
        logic        we;
        logic [1:0]  sel;
        logic        mirror;
        logic [15:0] eye_lo;
        logic [31:0] hprod;
        logic [20:0] a;
        logic [25:0] fprod;
        logic [24:0] frame_index;
        logic [31:0] frac;
        logic [34:0] n;
        logic [44:0] txprod;
        logic [11:0] tx;
        logic        nneg;
        logic [32:0] nmag;
        logic [19:0] rem;
        logic [11:0] q;
        logic [11:0] ty;
        logic [23:0] tidx;
        logic [31:0] fill;
    } pix_t;

endpackage

### hdl/rcm_regs.sv
// configuration register file behind the register bus
module rcm_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rcm_pkg::PADDR_W-1:0]  paddr,
    input  logic [rcm_pkg::PDATA_W-1:0]  pwdata,
    output logic [rcm_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output rcm_pkg::cfg_t                cfg
);
    import rcm_pkg::*;

    logic [31:0] ceiling_color_reg;
    logic [31:0] floor_color_reg;
    logic [12:0] texture_width_reg;
    logic [12:0] texture_height_reg;
    logic [12:0] screen_width_reg;
    logic [12:0] screen_height_reg;
    logic [13:0] frame_pitch_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[4:2];

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ceiling_color_reg  <= 32'd0;
            floor_color_reg    <= 32'd0;
            texture_width_reg  <= 13'd64;
            texture_height_reg <= 13'd64;
            screen_width_reg   <= 13'd640;
            screen_height_reg  <= 13'd480;
            frame_pitch_reg    <= 14'd640;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CEILING_COLOR:  ceiling_color_reg  <= pwdata;
                REG_FLOOR_COLOR:    floor_color_reg    <= pwdata;
                REG_TEXTURE_WIDTH:  texture_width_reg  <= pwdata[12:0];
                REG_TEXTURE_HEIGHT: texture_height_reg <= pwdata[12:0];
                REG_SCREEN_WIDTH:   screen_width_reg   <= pwdata[12:0];
                REG_SCREEN_HEIGHT:  screen_height_reg  <= pwdata[12:0];
                REG_FRAME_PITCH:    frame_pitch_reg    <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_idx)
            REG_CEILING_COLOR:  prdata = ceiling_color_reg;
            REG_FLOOR_COLOR:    prdata = floor_color_reg;
            REG_TEXTURE_WIDTH:  prdata = {19'd0, texture_width_reg};
            REG_TEXTURE_HEIGHT: prdata = {19'd0, texture_height_reg};
            REG_SCREEN_WIDTH:   prdata = {19'd0, screen_width_reg};
            REG_SCREEN_HEIGHT:  prdata = {19'd0, screen_height_reg};
            REG_FRAME_PITCH:    prdata = {18'd0, frame_pitch_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assign cfg.ceiling_color  = ceiling_color_reg;
    assign cfg.floor_color    = floor_color_reg;
    assign cfg.texture_width  = texture_width_reg;
    assign cfg.texture_height = texture_height_reg;
    assign cfg.screen_width   = screen_width_reg;
    assign cfg.screen_height  = screen_height_reg;
    assign cfg.frame_pitch    = frame_pitch_reg;

endmodule

### hdl/rcm_div.sv
// pipelined restoring divider, one quotient bit per stage, payload rides along
`include "raycast_wall_column_texel_mapper_defines.svh"
module rcm_div (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          in_valid,
    input  rcm_pkg::pix_t in_pix,
    output logic          out_valid,
    output rcm_pkg::pix_t out_pix
);
    import rcm_pkg::*;

    pix_t pix_reg [DIV_STEPS];
    logic vld_reg [DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_step
            pix_t        prv;
            pix_t        pix_next;
            logic        prv_vld;
            logic [20:0] trial;
            logic [20:0] diff;
            logic        ge;

            if (k == 0) begin : g_first
                assign prv     = in_pix;
                assign prv_vld = in_valid;
            end else begin : g_rest
                assign prv     = pix_reg[k-1];
                assign prv_vld = vld_reg[k-1];
            end

            // shift in the next dividend bit and try the subtract
            always_comb begin
                trial    = {prv.rem, prv.nmag[DIV_STEPS-1]};
                diff     = trial - {1'b0, prv.lh};
                ge       = trial >= {1'b0, prv.lh};
                pix_next = prv;
                pix_next.rem  = ge ? diff[19:0] : trial[19:0];
                pix_next.q    = {prv.q[10:0], ge};
                pix_next.nmag = {prv.nmag[DIV_STEPS-2:0], 1'b0};
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (adv) begin
                    vld_reg[k] <= prv_vld;
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    pix_reg[k] <= pix_next;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign out_pix   = pix_reg[DIV_STEPS-1];

    // remainder stays below a nonzero divisor
    `RCM_ASSERT_IMP(a_rem_below_divisor, aclk, aresetn,
        out_valid && (out_pix.lh != 20'd0), out_pix.rem < out_pix.lh)

endmodule

### hdl/raycast_wall_column_texel_mapper.sv
// top level of the raycaster wall column texel mapper
//
// One input beat per framebuffer pixel of a ray column: ray hit, slice height,
// first wall row, pixel row and column. One output beat per input beat, in
// order: region on m_tuser, framebuffer index, texture select, texel
// coordinates and index, and fill color on m_tdata.
// Registers are to be written over the register bus only while no pixel is
// in flight; the block itself does not enforce this. Throughput: one beat
// per clock while the receiver does not stall. The depth is set by the
// 33-stage texture row divider, one quotient bit per stage, with four stages
// before it for the products and two after it for the sign fix and texel index.
// Reset clears every stage valid bit and loads the register defaults
// (64x64 textures, 640x480 screen, pitch 640, black fill colors).
// When the receiver stalls with a result held, the whole pipeline holds; the
// input stage still takes one beat if it is empty, so s_tready stays high
// after the output backs up, until that beat is in. Nothing is lost or repeated.
`include "raycast_wall_column_texel_mapper_defines.svh"
module raycast_wall_column_texel_mapper (
    input  logic                           aclk,
    input  logic                           aresetn,
    // pixel input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // ray_dir_x, ray_dir_y, eye_x, eye_y, wall_distance, slice_height,
    // slice_top, pixel_row, pixel_column, zero pad
    input  logic [rcm_pkg::S_TDATA_W-1:0]  s_tdata,
    // hit_side
    input  logic [0:0]                     s_tuser,
    // texel output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // write_enable, frame_index, texture_select, texel_x, texel_y,
    // texel_index, fill_color, zero pad
    output logic [rcm_pkg::M_TDATA_W-1:0]  m_tdata,
    // region
    output logic [1:0]                     m_tuser,
    // register bus
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rcm_pkg::PADDR_W-1:0]    paddr,
    input  logic [rcm_pkg::PDATA_W-1:0]    pwdata,
    output logic [rcm_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import rcm_pkg::*;

    cfg_t cfg;

    pix_t st0_reg, st1_reg, st2_reg, st3_reg, st4_reg, st5_reg, st6_reg;
    pix_t st0_next, st1_next, st2_next, st3_next, st4_next, st5_next, st6_next;
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic adv;
    logic div_vld;
    pix_t div_pix;

    logic signed [13:0] draw_end;
    logic [20:0]        dsel;
    logic signed [45:0] hp;
    logic signed [34:0] nfull;
    logic [34:0]        nabs;
    logic [12:0]        txh;
    logic [12:0]        txm;
    logic [11:0]        qf;
    logic [12:0]        thm1;
    logic [24:0]        tidx_full;

    rcm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // global advance, input stage may still fill a bubble
    assign adv      = !v6_reg || m_tready;
    assign s_tready = adv || !v0_reg;

    // stage 0: unpack the input beat
    always_comb begin
        st0_next           = '0;
        st0_next.side      = s_tuser[0];
        st0_next.dir_x     = s_tdata[20:0];
        st0_next.dir_y     = s_tdata[41:21];
        st0_next.eye_x     = s_tdata[65:42];
        st0_next.eye_y     = s_tdata[89:66];
        st0_next.wall_dist = s_tdata[113:90];
        st0_next.lh        = s_tdata[133:114];
        st0_next.top       = s_tdata[145:134];
        st0_next.row       = s_tdata[157:146];
        st0_next.col       = s_tdata[169:158];
    end

    // stage 1: region, texture choice, hit product, row offset, row product
    always_comb begin
        st1_next = st0_reg;
        draw_end = $signed({1'b0, cfg.screen_height}) - $signed({2'b00, st0_reg.top});
        if ($signed({2'b00, st0_reg.row}) >= draw_end) begin
            st1_next.region = REGION_FLOOR;
            st1_next.fill   = cfg.floor_color;
        end else if (st0_reg.row < st0_reg.top) begin
            st1_next.region = REGION_CEILING;
            st1_next.fill   = cfg.ceiling_color;
        end else begin
            st1_next.region = REGION_WALL;
            st1_next.fill   = 32'd0;
        end
        st1_next.we = ({1'b0, st0_reg.row} < cfg.screen_height) &&
                      ({1'b0, st0_reg.col} < cfg.screen_width);
        if (!st0_reg.side) begin
            st1_next.sel    = st0_reg.dir_x[20] ? TEX_WEST : TEX_EAST;
            st1_next.mirror = !st0_reg.dir_x[20] && (st0_reg.dir_x != 21'd0);
            st1_next.eye_lo = st0_reg.eye_y[15:0];
            dsel            = st0_reg.dir_y;
        end else begin
            st1_next.sel    = st0_reg.dir_y[20] ? TEX_NORTH : TEX_SOUTH;
            st1_next.mirror = st0_reg.dir_y[20];
            st1_next.eye_lo = st0_reg.eye_x[15:0];
            dsel            = st0_reg.dir_x;
        end
        hp             = $signed({1'b0, st0_reg.wall_dist}) * $signed(dsel);
        st1_next.hprod = hp[31:0];
        st1_next.a     = {9'd0, st0_reg.row} - {9'd0, cfg.screen_height[12:1]}
                         + {2'b00, st0_reg.lh[19:1]};
        st1_next.fprod = 26'(st0_reg.row) * 26'(cfg.frame_pitch);
    end

    // stage 2: wall hit fraction, row numerator, framebuffer index
    always_comb begin
        st2_next             = st1_reg;
        st2_next.frac        = {st1_reg.eye_lo, 16'd0} + st1_reg.hprod;
        nfull                = $signed(st1_reg.a) * $signed({1'b0, cfg.texture_height});
        st2_next.n           = nfull;
        st2_next.frame_index = st1_reg.fprod[24:0] + 25'(st1_reg.col);
    end

    // stage 3: column product, numerator sign and magnitude
    always_comb begin
        st3_next        = st2_reg;
        st3_next.txprod = 45'(st2_reg.frac) * 45'(cfg.texture_width);
        nabs            = 35'd0 - st2_reg.n;
        st3_next.nneg   = st2_reg.n[34];
        st3_next.nmag   = st2_reg.n[34] ? nabs[32:0] : st2_reg.n[32:0];
        st3_next.rem    = 20'd0;
        st3_next.q      = 12'd0;
    end

    // stage 4: texture column with mirroring
    always_comb begin
        st4_next = st3_reg;
        txh      = st3_reg.txprod[44:32];
        txm      = cfg.texture_width - txh - 13'd1;
        if (cfg.texture_width == 13'd0) begin
            st4_next.tx = 12'd0;
        end else if (st3_reg.mirror) begin
            st4_next.tx = txm[11:0];
        end else begin
            st4_next.tx = txh[11:0];
        end
    end

    rcm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v4_reg),
        .in_pix    (st4_reg),
        .out_valid (div_vld),
        .out_pix   (div_pix)
    );

    // stage 5: floor the signed quotient, mask the texture row
    always_comb begin
        st5_next = div_pix;
        thm1     = cfg.texture_height - 13'd1;
        if (!div_pix.nneg) begin
            qf = div_pix.q;
        end else if (div_pix.rem != 20'd0) begin
            qf = ~div_pix.q;
        end else begin
            qf = 12'd0 - div_pix.q;
        end
        if ((cfg.texture_height == 13'd0) || (div_pix.lh == 20'd0)) begin
            st5_next.ty = 12'd0;
        end else begin
            st5_next.ty = qf & thm1[11:0];
        end
        // ceiling and floor rows carry no texel
        if (div_pix.region != REGION_WALL) begin
            st5_next.sel = TEX_WEST;
            st5_next.tx  = 12'd0;
            st5_next.ty  = 12'd0;
        end
    end

    // stage 6: texel index, output register
    always_comb begin
        st6_next      = st5_reg;
        tidx_full     = 25'(st5_reg.ty) * 25'(cfg.texture_width) + 25'(st5_reg.tx);
        st6_next.tidx = tidx_full[23:0];
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                v0_reg <= s_tvalid;
            end
            if (adv) begin
                v1_reg <= v0_reg;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
                v5_reg <= div_vld;
                v6_reg <= v5_reg;
            end
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (s_tready) begin
            st0_reg <= st0_next;
        end
        if (adv) begin
            st1_reg <= st1_next;
            st2_reg <= st2_next;
            st3_reg <= st3_next;
            st4_reg <= st4_next;
            st5_reg <= st5_next;
            st6_reg <= st6_next;
        end
    end

    // output beat
    assign m_tvalid = v6_reg;
    assign m_tuser  = st6_reg.region;
    assign m_tdata  = {4'd0, st6_reg.fill, st6_reg.tidx, st6_reg.ty, st6_reg.tx,
                       st6_reg.sel, st6_reg.frame_index, st6_reg.we};

    // wall rows never carry a fill color
    `RCM_ASSERT_IMP(a_wall_no_fill, aclk, aresetn,
        v6_reg && (st6_reg.region == REGION_WALL), st6_reg.fill == 32'd0)

    // ceiling and floor rows carry no texel
    `RCM_ASSERT_IMP(a_flat_no_texel, aclk, aresetn,
        v6_reg && (st6_reg.region != REGION_WALL),
        (st6_reg.tidx == 24'd0) && (st6_reg.tx == 12'd0) && (st6_reg.ty == 12'd0))

    // mirrored or not, the texture column stays inside the texture
    `RCM_ASSERT_IMP(a_tx_in_texture, aclk, aresetn,
        v6_reg && (st6_reg.region == REGION_WALL) && (cfg.texture_width != 13'd0) &&
        (cfg.texture_width <= 13'd4096),
        {1'b0, st6_reg.tx} < cfg.texture_width)

endmodule

### tb/raycast_wall_column_texel_mapper_tb.sv
// self-checking testbench for the raycaster wall column texel mapper
`timescale 1ns / 1ps

module raycast_wall_column_texel_mapper_tb;
    import rcm_pkg::*;

    localparam int QUIET_LIMIT    = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 205;
    localparam int SETTING_COUNT  = 6;
    localparam int TAIL_CYCLES    = 60;
    localparam int MAX_PRINTED    = 30;

    // one pixel beat as the sender sees it
    typedef struct packed {
        logic        hit_side;
        logic [20:0] ray_dir_x;
        logic [20:0] ray_dir_y;
        logic [23:0] eye_x;
        logic [23:0] eye_y;
        logic [23:0] wall_distance;
        logic [19:0] slice_height;
        logic [11:0] slice_top;
        logic [11:0] pixel_row;
        logic [11:0] pixel_column;
    } pixel_t;

    // one result beat, unpacked
    typedef struct packed {
        logic [1:0]  region;
        logic        write_enable;
        logic [24:0] frame_index;
        logic [1:0]  texture_select;
        logic [11:0] texel_x;
        logic [11:0] texel_y;
        logic [23:0] texel_index;
        logic [31:0] fill_color;
    } texel_t;

    // texel predictions in beat order plus the register mirror
    class texel_scoreboard;
        texel_t expected_texels[$];
        cfg_t   cfg;
        int     errors;
        int     checked;
        int     region_seen[3];

        function new();
            cfg.ceiling_color  = 32'd0;
            cfg.floor_color    = 32'd0;
            cfg.texture_width  = 13'd64;
            cfg.texture_height = 13'd64;
            cfg.screen_width   = 13'd640;
            cfg.screen_height  = 13'd480;
            cfg.frame_pitch    = 14'd640;
            errors  = 0;
            checked = 0;
            region_seen = '{0, 0, 0};
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_CEILING_COLOR:  cfg.ceiling_color  = value;
                REG_FLOOR_COLOR:    cfg.floor_color    = value;
                REG_TEXTURE_WIDTH:  cfg.texture_width  = value[12:0];
                REG_TEXTURE_HEIGHT: cfg.texture_height = value[12:0];
                REG_SCREEN_WIDTH:   cfg.screen_width   = value[12:0];
                REG_SCREEN_HEIGHT:  cfg.screen_height  = value[12:0];
                REG_FRAME_PITCH:    cfg.frame_pitch    = value[13:0];
                default: ;
            endcase
        endfunction

        function texel_t predict_texel(pixel_t p);
            texel_t t;
            longint dir_x, dir_y, eye_x, eye_y, wall_dist;
            longint h, top, row, lh, draw_end, hit, n, q;
            longint unsigned frac, tx, ty, tw, th, tidx, fidx;
            t = '0;
            dir_x = $signed(p.ray_dir_x);
            dir_y = $signed(p.ray_dir_y);
            eye_x = p.eye_x;
            eye_y = p.eye_y;
            wall_dist = p.wall_distance;
            h     = cfg.screen_height;
            top   = p.slice_top;
            row   = p.pixel_row;
            lh    = p.slice_height;
            tw    = cfg.texture_width;
            th    = cfg.texture_height;
            tx    = 0;
            ty    = 0;
            draw_end = h - top;
            t.write_enable = (row < h) && (p.pixel_column < cfg.screen_width);
            fidx = row * cfg.frame_pitch + p.pixel_column;
            t.frame_index = fidx[24:0];

            // floor wins over ceiling when the slice overlaps itself
            if (row >= draw_end) begin
                t.region     = REGION_FLOOR;
                t.fill_color = cfg.floor_color;
            end else if (row < top) begin
                t.region     = REGION_CEILING;
                t.fill_color = cfg.ceiling_color;
            end else begin
                t.region = REGION_WALL;
                if (p.hit_side == 1'b0) begin
                    t.texture_select = (dir_x < 0) ? TEX_WEST : TEX_EAST;
                    hit = eye_y * 65536 + wall_dist * dir_y;
                end else begin
                    t.texture_select = (dir_y < 0) ? TEX_NORTH : TEX_SOUTH;
                    hit = eye_x * 65536 + wall_dist * dir_x;
                end
                // fractional wall hit scaled to a texture column
                frac = hit & 64'hFFFF_FFFF;
                if (tw != 0) begin
                    tx = (frac * tw) >> 32;
                    if ((p.hit_side == 1'b0 && dir_x > 0) || (p.hit_side == 1'b1 && dir_y < 0))
                        tx = tw - tx - 1;
                end
                // texture row, floored quotient
                if (th != 0 && lh != 0) begin
                    n = (row - h / 2 + lh / 2) * longint'(th);
                    q = n / lh;
                    if ((n % lh) != 0 && n < 0)
                        q = q - 1;
                    ty = q & (th - 1);
                end
                tx   = tx & 64'hFFF;
                ty   = ty & 64'hFFF;
                tidx = (ty * tw + tx) & 64'hFF_FFFF;
                t.texel_x     = tx[11:0];
                t.texel_y     = ty[11:0];
                t.texel_index = tidx[23:0];
            end
            return t;
        endfunction

        function void note_pixel(pixel_t p);
            expected_texels.push_back(predict_texel(p));
        endfunction

        task report_mismatch(string what);
            if (errors < MAX_PRINTED)
                $display("mismatch at result %0d: %s", checked, what);
            errors++;
        endtask

        task compare_field(string name, longint unsigned got, longint unsigned want);
            if (got != want)
                report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        endtask

        task check_texel(texel_t got);
            texel_t want;
            if (expected_texels.size() == 0) begin
                report_mismatch("result beat with nothing outstanding");
            end else begin
                want = expected_texels.pop_front();
                compare_field("region", got.region, want.region);
                compare_field("write_enable", got.write_enable, want.write_enable);
                compare_field("frame_index", got.frame_index, want.frame_index);
                compare_field("texture_select", got.texture_select, want.texture_select);
                compare_field("texel_x", got.texel_x, want.texel_x);
                compare_field("texel_y", got.texel_y, want.texel_y);
                compare_field("texel_index", got.texel_index, want.texel_index);
                compare_field("fill_color", got.fill_color, want.fill_color);
                if (want.region <= REGION_FLOOR)
                    region_seen[want.region]++;
            end
            checked++;
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    texel_scoreboard sb;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit hold_request = 1'b0;
    int pixels_sent  = 0;
    int quiet_cycles = 0;

    raycast_wall_column_texel_mapper u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog on cycles with no beat and no register access
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // result side: random backpressure, long hold on request, check every beat
    initial begin : result_sink
        texel_t got;
        int     hold_left;
        hold_left = 0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got.region         = m_tuser;
                got.write_enable   = m_tdata[0];
                got.frame_index    = m_tdata[25:1];
                got.texture_select = m_tdata[27:26];
                got.texel_x        = m_tdata[39:28];
                got.texel_y        = m_tdata[51:40];
                got.texel_index    = m_tdata[75:52];
                got.fill_color     = m_tdata[107:76];
                sb.check_texel(got);
            end
        end
    end

    function automatic pixel_t mk_pixel(bit side, int dx, int dy, int ex, int ey,
                                        int wall_dist, int lh, int top, int row, int col);
        pixel_t p;
        p.hit_side      = side;
        p.ray_dir_x     = 21'(dx);
        p.ray_dir_y     = 21'(dy);
        p.eye_x         = 24'(ex);
        p.eye_y         = 24'(ey);
        p.wall_distance = 24'(wall_dist);
        p.slice_height  = 20'(lh);
        p.slice_top     = 12'(top);
        p.pixel_row     = 12'(row);
        p.pixel_column  = 12'(col);
        return p;
    endfunction

    // mostly well-formed column pixels for the current screen, some raw noise
    function automatic pixel_t random_pixel();
        pixel_t p;
        int h, w, lh, top, draw_end, hi;
        h = sb.cfg.screen_height;
        w = sb.cfg.screen_width;
        p.hit_side      = 1'($urandom_range(0, 1));
        p.ray_dir_x     = ($urandom_range(0, 15) == 0) ? 21'd0 : 21'($urandom);
        p.ray_dir_y     = ($urandom_range(0, 15) == 0) ? 21'd0 : 21'($urandom);
        p.eye_x         = 24'($urandom);
        p.eye_y         = 24'($urandom);
        p.wall_distance = ($urandom_range(0, 7) == 0) ? 24'($urandom_range(0, 255))
                                                      : 24'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            p.slice_height = 20'($urandom);
            p.slice_top    = 12'($urandom);
            p.pixel_row    = 12'($urandom);
            p.pixel_column = 12'($urandom);
        end else begin
            case ($urandom_range(0, 3))
                0:       lh = $urandom_range(1, 64);
                1:       lh = $urandom_range(1, h + 1);
                2:       lh = $urandom_range(h, 4 * h + 1);
                default: lh = $urandom_range(1, 20'hFFFFF);
            endcase
            // slice centered on the screen, top clamped like a raycaster does
            top = h / 2 - lh / 2;
            if (top < 0) top = 0;
            if (top > 4095) top = 4095;
            draw_end = h - top;
            hi = draw_end - 1;
            if (hi < top) hi = top;
            if (hi > 4095) hi = 4095;
            case ($urandom_range(0, 4))
                0, 1, 2: p.pixel_row = 12'($urandom_range(top, hi));
                3:       p.pixel_row = 12'($urandom_range(0, (h < 4095) ? h : 4095));
                default: p.pixel_row = 12'($urandom);
            endcase
            p.pixel_column = ($urandom_range(0, 7) == 0) ? 12'($urandom)
                           : 12'($urandom_range(0, (w < 4095) ? w : 4095));
            p.slice_height = 20'(lh);
            p.slice_top    = 12'(top);
        end
        return p;
    endfunction

    // register settings: extremes, random, zero and oversized textures, typical
    function automatic cfg_t make_setting(int k);
        cfg_t c;
        c.ceiling_color  = $urandom;
        c.floor_color    = $urandom;
        c.texture_width  = 13'($urandom_range(1, 4096));
        c.texture_height = 13'(1 << $urandom_range(0, 12));
        c.screen_width   = 13'($urandom_range(1, 4096));
        c.screen_height  = 13'($urandom_range(1, 4096));
        c.frame_pitch    = 14'($urandom_range(1, 8192));
        case (k)
            0: begin
                c.ceiling_color = 32'hFFFF_FFFF; c.floor_color = 32'd0;
                c.texture_width = 13'd4096; c.texture_height = 13'd4096;
                c.screen_width = 13'd4096; c.screen_height = 13'd4096;
                c.frame_pitch = 14'd8192;
            end
            1: begin
                c.ceiling_color = 32'd0; c.floor_color = 32'hFFFF_FFFF;
                c.texture_width = 13'd1; c.texture_height = 13'd1;
                c.screen_width = 13'd1; c.screen_height = 13'd1;
                c.frame_pitch = 14'd1;
            end
            3: begin
                c.texture_width = 13'd0; c.texture_height = 13'd0;
            end
            4: begin
                c.texture_width = 13'h1FFF; c.texture_height = 13'h1FFF;
                c.screen_width = 13'd640; c.screen_height = 13'd480;
                c.frame_pitch = 14'd5000;
            end
            5: begin
                c.texture_width = 13'd64; c.texture_height = 13'd64;
                c.screen_width = 13'd640; c.screen_height = 13'd480;
                c.frame_pitch = 14'd640;
            end
            default: ;
        endcase
        return c;
    endfunction

    // offer one pixel beat, with random idle cycles ahead of it
    task automatic send_pixel(input pixel_t p);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= p.hit_side;
        s_tdata  <= {6'd0, p.pixel_column, p.pixel_row, p.slice_top, p.slice_height,
                     p.wall_distance, p.eye_y, p.eye_x, p.ray_dir_y, p.ray_dir_x};
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(p);
        pixels_sent++;
    endtask

    // stop offering and wait until every result has come back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (sb.expected_texels.size() != 0) @(posedge aclk);
    endtask

    // register write: setup cycle, then access cycle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, value);
    endtask

    task automatic apply_config(input cfg_t c);
        write_reg(REG_CEILING_COLOR, c.ceiling_color);
        write_reg(REG_FLOOR_COLOR, c.floor_color);
        write_reg(REG_TEXTURE_WIDTH, 32'(c.texture_width));
        write_reg(REG_TEXTURE_HEIGHT, 32'(c.texture_height));
        write_reg(REG_SCREEN_WIDTH, 32'(c.screen_width));
        write_reg(REG_SCREEN_HEIGHT, 32'(c.screen_height));
        write_reg(REG_FRAME_PITCH, 32'(c.frame_pitch));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // main sequence
    initial begin : main_seq
        pixel_t directed_px[$];
        sb = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed pixels at the reset setting (480 rows, slice top mostly 100)
        src_idle_pct = 33;
        snk_idle_pct = 79;
        directed_px.push_back(mk_pixel(0, -65536, 32768, 'h20000, 'h38000, 'h18000,
                                       280, 100, 0, 0));
        directed_px.push_back(mk_pixel(0, -65536, 32768, 'h20000, 'h38000, 'h18000,
                                       280, 100, 100, 1));
        directed_px.push_back(mk_pixel(0, -65536, 32768, 'h20000, 'h38000, 'h18000,
                                       280, 100, 379, 2));
        // first row at the slice end is floor
        directed_px.push_back(mk_pixel(0, -65536, 32768, 'h20000, 'h38000, 'h18000,
                                       280, 100, 380, 3));
        // overlapping slice, floor has priority
        directed_px.push_back(mk_pixel(1, 1000, 2000, 'h11111, 'h22222, 'h33333,
                                       10, 300, 250, 4));
        // texture select and mirroring for both sides and all signs
        directed_px.push_back(mk_pixel(0, 65536, 12345, 'h4567, 'h89AB, 'h1CDEF,
                                       280, 100, 200, 5));
        directed_px.push_back(mk_pixel(0, 0, -54321, 'h4567, 'h89AB, 'h1CDEF,
                                       280, 100, 200, 6));
        directed_px.push_back(mk_pixel(1, 40000, -70000, 'h4567, 'h89AB, 'h1CDEF,
                                       280, 100, 200, 7));
        directed_px.push_back(mk_pixel(1, -40000, 70000, 'h4567, 'h89AB, 'h1CDEF,
                                       280, 100, 200, 8));
        directed_px.push_back(mk_pixel(1, -40000, 0, 'h4567, 'h89AB, 'h1CDEF,
                                       280, 100, 200, 9));
        // direction and position extremes
        directed_px.push_back(mk_pixel(0, -1048576, 1048575, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF,
                                       280, 100, 200, 639));
        directed_px.push_back(mk_pixel(1, 1048575, -1048576, 0, 0, 'hFFFFFF,
                                       280, 100, 150, 10));
        directed_px.push_back(mk_pixel(1, 1048575, 1048575, 'hFFFFFF, 'hFFFFFF, 0,
                                       280, 100, 150, 11));
        // smallest and largest slice heights, and a zero slice height
        directed_px.push_back(mk_pixel(0, -3, 5, 'h10000, 'h10000, 'h8000, 1, 239, 239, 12));
        directed_px.push_back(mk_pixel(0, 3, -5, 'h10000, 'h10000, 'h8000,
                                       1048575, 0, 0, 13));
        directed_px.push_back(mk_pixel(1, 3, -5, 'h10000, 'h10000, 'h8000, 0, 0, 10, 14));
        // wall row above the slice center gives a negative row numerator
        directed_px.push_back(mk_pixel(0, -100, 200, 'h30000, 'h50000, 'h2000, 100, 0, 10, 15));
        // off screen column and row
        directed_px.push_back(mk_pixel(0, -100, 200, 'h30000, 'h50000, 'h2000,
                                       1048575, 0, 479, 640));
        directed_px.push_back(mk_pixel(1, -100, 200, 'h30000, 'h50000, 'h2000,
                                       1048575, 0, 480, 0));
        // slice top past the screen bottom
        directed_px.push_back(mk_pixel(1, 100, 200, 'h30000, 'h50000, 'h2000,
                                       50, 4095, 4095, 4095));
        directed_px.push_back(mk_pixel(0, 100, 200, 'h30000, 'h50000, 'h2000,
                                       50, 4095, 0, 20));
        directed_px.push_back(mk_pixel(0, 77, 88, 0, 0, 0, 480, 0, 0, 21));
        foreach (directed_px[i])
            send_pixel(directed_px[i]);
        wait_drain();

        // random phases, one register setting each
        for (int k = 0; k < SETTING_COUNT; k++) begin
            apply_config(make_setting(k));
            if (k < 2) begin
                src_idle_pct = 33;
                snk_idle_pct = 79;
            end else if (k < 4) begin
                src_idle_pct = 79;
                snk_idle_pct = 33;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            // long receiver hold so the pipeline fills and s_tready drops
            if (k == 4)
                hold_request = 1'b1;
            repeat (PHASE_ITEMS)
                send_pixel(random_pixel());
            wait_drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.expected_texels.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived",
                                         sb.expected_texels.size()));
        $display("covered %0d pixel beats over %0d register settings, %0d results checked",
                 pixels_sent, SETTING_COUNT + 1, sb.checked);
        $display("rows by class: %0d ceiling, %0d wall, %0d floor; %0d mismatches",
                 sb.region_seen[0], sb.region_seen[1], sb.region_seen[2], sb.errors);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### raycast_wall_column_texel_mapper.f
+incdir+hdl
hdl/rcm_pkg.sv
hdl/rcm_regs.sv
hdl/rcm_div.sv
hdl/raycast_wall_column_texel_mapper.sv
tb/raycast_wall_column_texel_mapper_tb.sv
